@@ sv/sofm_pkg.sv @@
// Shared constants, types, command struct and sine ROM contents for the FM sine oscillator.
`timescale 1ns / 1ps

package sofm_pkg;

  // Core sizing.
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int TABLE_LEN       = 1 << TABLE_ADDR_BITS;

  // Register and input field widths.
  localparam int TW_W       = 32;
  localparam int GAIN_W     = 16;
  localparam int MI_W       = 16;
  localparam int MOD_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Shared multiplier: TW_W by MUL_B_W unsigned.
  localparam int MUL_B_W = (SAMPLE_BITS > MOD_W) ? SAMPLE_BITS : MOD_W;
  localparam int MUL_P_W = TW_W + MUL_B_W;

  // Frequency shift partial products.
  localparam int A_W      = TW_W + MI_W;
  localparam int P0_W     = TW_W + MOD_W;
  localparam int P1_W     = MI_W + MOD_W;
  localparam int FM_SHIFT = 23;
  localparam int INC_W    = 64;
  localparam int MAG_W    = INC_W - FM_SHIFT;

  // Output scaling.
  localparam int GAIN_FRAC = 15;
  localparam int PROD_W    = GAIN_W + SAMPLE_BITS;
  localparam int RND_W     = PROD_W + 1;
  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(64'd1 << (GAIN_FRAC - 1));
  localparam logic signed [RND_W-1:0] SAT_MAX  =
    RND_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [RND_W-1:0] SAT_MIN  = ~SAT_MAX;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TUNING_WORD     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE_GAIN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FM_ENABLE       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_INDEX       = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_TUNING_WORD = CFG_IDX_W'(4);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic mul_gain;
    logic mul_fm_a;
    logic mul_fm_lo;
    logic mul_fm_hi;
    logic step_phase;
    logic load_out;
  } dp_cmd_t;

  // Quarter-wave sine table.
  typedef logic [SAMPLE_BITS-1:0] rom_word_t;
  typedef rom_word_t [TABLE_LEN-1:0] rom_t;

  // Fixed-point Taylor series (Q30, Horner form, truncating) evaluated at
  // the center of each table bin, scaled to full scale and clamped.
  function automatic rom_t build_sine_rom();
    rom_t        rom;
    logic [63:0] q30_one;
    logic [63:0] half_pi;
    logic [63:0] smax;
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    q30_one = 64'd1 << 30;
    half_pi = 64'd1686629713;
    smax    = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    for (int k = 0; k < TABLE_LEN; k++) begin
      u  = 64'(2 * k + 1);
      x  = (u * half_pi) >> (TABLE_ADDR_BITS + 1);
      x2 = (x * x) >> 30;
      t  = q30_one - (((x2 * q30_one) >> 30) / 72);
      t  = q30_one - (((x2 * t) >> 30) / 42);
      t  = q30_one - (((x2 * t) >> 30) / 20);
      t  = q30_one - (((x2 * t) >> 30) / 6);
      s  = (x * t) >> 30;
      v  = (s * smax + (64'd1 << 29)) >> 30;
      if (v > smax) begin
        v = smax;
      end
      rom[k] = SAMPLE_BITS'(v);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_sine_rom();

endpackage

@@ sv/sofm_dp.sv @@
// Datapath: configuration registers, phase accumulator, sine ROM and shared multiplier.
`timescale 1ns / 1ps

module sofm_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  sofm_pkg::dp_cmd_t                       cmd,
  input  logic                                    cfg_valid,
  input  logic [sofm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sofm_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic signed [sofm_pkg::MOD_W-1:0]       in_mod_sample,
  output logic signed [sofm_pkg::SAMPLE_BITS-1:0] out_sample
);

  // Configuration registers.
  logic [sofm_pkg::TW_W-1:0]   tw_r;
  logic [sofm_pkg::GAIN_W-1:0] gain_r;
  logic                        fm_en_r;
  logic [sofm_pkg::MI_W-1:0]   mi_r;
  logic [sofm_pkg::TW_W-1:0]   mtw_r;

  // Oscillator state and per-request working registers.
  logic [sofm_pkg::PHASE_BITS-1:0]      phase_r;
  logic [sofm_pkg::PHASE_BITS-1:0]      phase_nxt;
  logic [sofm_pkg::TABLE_ADDR_BITS-1:0] rom_addr;
  logic [sofm_pkg::SAMPLE_BITS-1:0]     rom_q_r;
  logic                                 rom_neg_r;
  logic                                 gneg_r;
  logic [sofm_pkg::PROD_W-1:0]          gp_r;
  logic                                 mod_neg_r;
  logic [sofm_pkg::MOD_W-1:0]           mod_mag_r;
  logic [sofm_pkg::A_W-1:0]             a_r;
  logic [sofm_pkg::P0_W-1:0]            p0_r;
  logic [sofm_pkg::MAG_W-1:0]           mag_r;
  logic [sofm_pkg::MAG_W-1:0]           mag_nxt;
  logic [sofm_pkg::INC_W-1:0]           inc;
  logic [sofm_pkg::SAMPLE_BITS-1:0]     out_sample_r;
  logic [sofm_pkg::SAMPLE_BITS-1:0]     sample_nxt;

  // Shared multiplier operands and product.
  logic [sofm_pkg::TW_W-1:0]    mul_x;
  logic [sofm_pkg::MUL_B_W-1:0] mul_y;
  logic [sofm_pkg::MUL_P_W-1:0] mul_p;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r    <= '0;
      gain_r  <= sofm_pkg::GAIN_W'(32768);
      fm_en_r <= 1'b0;
      mi_r    <= sofm_pkg::MI_W'(256);
      mtw_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sofm_pkg::CFG_TUNING_WORD:     tw_r    <= cfg_data[sofm_pkg::TW_W-1:0];
        sofm_pkg::CFG_AMPLITUDE_GAIN:  gain_r  <= cfg_data[sofm_pkg::GAIN_W-1:0];
        sofm_pkg::CFG_FM_ENABLE:       fm_en_r <= cfg_data[0];
        sofm_pkg::CFG_MOD_INDEX:       mi_r    <= cfg_data[sofm_pkg::MI_W-1:0];
        sofm_pkg::CFG_MOD_TUNING_WORD: mtw_r   <= cfg_data[sofm_pkg::TW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Quarter-wave addressing: mirror the address in odd quadrants.
  always_comb begin
    rom_addr = phase_r[sofm_pkg::PHASE_BITS-3 -: sofm_pkg::TABLE_ADDR_BITS];
    if (phase_r[sofm_pkg::PHASE_BITS-2]) begin
      rom_addr = ~rom_addr;
    end
  end

  // Registered ROM read follows the phase every cycle.
  always_ff @(posedge clk) begin
    rom_q_r   <= sofm_pkg::SINE_ROM[rom_addr];
    rom_neg_r <= phase_r[sofm_pkg::PHASE_BITS-1];
  end

  // Operand selection for the one shared multiplier.
  always_comb begin
    priority if (cmd.mul_gain) begin
      mul_x = sofm_pkg::TW_W'(gain_r);
      mul_y = sofm_pkg::MUL_B_W'(rom_q_r);
    end else if (cmd.mul_fm_a) begin
      mul_x = mtw_r;
      mul_y = sofm_pkg::MUL_B_W'(mi_r);
    end else if (cmd.mul_fm_lo) begin
      mul_x = a_r[sofm_pkg::TW_W-1:0];
      mul_y = sofm_pkg::MUL_B_W'(mod_mag_r);
    end else begin
      mul_x = sofm_pkg::TW_W'(a_r[sofm_pkg::A_W-1:sofm_pkg::TW_W]);
      mul_y = sofm_pkg::MUL_B_W'(mod_mag_r);
    end
    mul_p = sofm_pkg::MUL_P_W'(mul_x) * sofm_pkg::MUL_P_W'(mul_y);
  end

  // Frequency shift: (low product >> 23) plus high product moved up by the
  // width of the low half less 23, which is exact for the bits the phase can use.
  assign mag_nxt = sofm_pkg::MAG_W'(p0_r >> sofm_pkg::FM_SHIFT)
                 + (sofm_pkg::MAG_W'(mul_p[sofm_pkg::P1_W-1:0])
                    << (sofm_pkg::TW_W - sofm_pkg::FM_SHIFT));

  // Phase increment wraps modulo a full turn in either direction.
  always_comb begin
    if (mod_neg_r) begin
      inc = sofm_pkg::INC_W'(tw_r) - sofm_pkg::INC_W'(mag_r);
    end else begin
      inc = sofm_pkg::INC_W'(tw_r) + sofm_pkg::INC_W'(mag_r);
    end
    phase_nxt = phase_r + inc[sofm_pkg::PHASE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cmd.step_phase) begin
      phase_r <= phase_nxt;
    end
  end

  // Working registers loaded at each step of a request.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mod_neg_r <= in_mod_sample[sofm_pkg::MOD_W-1];
      mod_mag_r <= in_mod_sample[sofm_pkg::MOD_W-1] ?
                   sofm_pkg::MOD_W'(-in_mod_sample) : sofm_pkg::MOD_W'(in_mod_sample);
    end
    if (cmd.mul_gain) begin
      gp_r   <= mul_p[sofm_pkg::PROD_W-1:0];
      gneg_r <= rom_neg_r;
    end
    if (cmd.mul_fm_a) begin
      a_r <= mul_p[sofm_pkg::A_W-1:0];
    end
    if (cmd.mul_fm_lo) begin
      p0_r <= mul_p[sofm_pkg::P0_W-1:0];
    end
    if (cmd.mul_fm_hi) begin
      mag_r <= fm_en_r ? mag_nxt : '0;
    end
    if (cmd.load_out) begin
      out_sample_r <= sample_nxt;
    end
  end

  // Apply the quadrant sign, round half up and saturate.
  always_comb begin
    logic signed [sofm_pkg::RND_W-1:0] sprod;
    logic signed [sofm_pkg::RND_W-1:0] rnd;
    logic signed [sofm_pkg::RND_W-1:0] shifted;
    sprod   = gneg_r ? -$signed({1'b0, gp_r}) : $signed({1'b0, gp_r});
    rnd     = sprod + sofm_pkg::RND_HALF;
    shifted = rnd >>> sofm_pkg::GAIN_FRAC;
    if (shifted > sofm_pkg::SAT_MAX) begin
      sample_nxt = sofm_pkg::SAT_MAX[sofm_pkg::SAMPLE_BITS-1:0];
    end else if (shifted < sofm_pkg::SAT_MIN) begin
      sample_nxt = sofm_pkg::SAT_MIN[sofm_pkg::SAMPLE_BITS-1:0];
    end else begin
      sample_nxt = shifted[sofm_pkg::SAMPLE_BITS-1:0];
    end
  end

  assign out_sample = $signed(out_sample_r);

endmodule

@@ sv/sofm_ctrl.sv @@
// Controller: sequences one request through the shared multiplier and owns the output valid.
`timescale 1ns / 1ps

module sofm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sofm_pkg::dp_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_GAIN   = 3'd1;
  localparam logic [2:0] ST_FM_A   = 3'd2;
  localparam logic [2:0] ST_FM_LO  = 3'd3;
  localparam logic [2:0] ST_FM_HI  = 3'd4;
  localparam logic [2:0] ST_PHASE  = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_GAIN;
        end
      end
      ST_GAIN: begin
        cmd.mul_gain = 1'b1;
        state_nxt    = ST_FM_A;
      end
      ST_FM_A: begin
        cmd.mul_fm_a = 1'b1;
        state_nxt    = ST_FM_LO;
      end
      ST_FM_LO: begin
        cmd.mul_fm_lo = 1'b1;
        state_nxt     = ST_FM_HI;
      end
      ST_FM_HI: begin
        cmd.mul_fm_hi = 1'b1;
        state_nxt     = ST_PHASE;
      end
      ST_PHASE: begin
        cmd.step_phase = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register valid: cleared when taken, set when a result is loaded.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/sine_oscillator_with_fm.sv @@
// Top level of the DDS sine oscillator with frequency modulation.
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// in        in_valid / in_ready      in_mod_sample (signed 16)
// out       out_valid / out_ready    out_sample (signed 16)
// cfg       cfg_valid / cfg_ready    cfg_index (3), cfg_data (32)
//
// Each request is accepted, then takes four passes through the single
// shared 32x16 multiplier, one phase update and one output load before
// the next request can be accepted.
// A result waits in the output register; the next request is accepted
// while it waits, and only the final load stalls until out_ready frees it.
// Reset is synchronous; configuration writes are taken in every cycle.

module sine_oscillator_with_fm (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [sofm_pkg::MOD_W-1:0]       in_mod_sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [sofm_pkg::SAMPLE_BITS-1:0] out_sample,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [sofm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sofm_pkg::CFG_DATA_W-1:0]         cfg_data
);

  sofm_pkg::dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // Sequencer.
  sofm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Arithmetic, state and registers.
  sofm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_mod_sample (in_mod_sample),
    .out_sample    (out_sample)
  );

endmodule
